// ----- rtl/core/tmh_pkg.sv -----
// timer heap package: action and status codes, result payload struct
// no dependencies
`default_nettype none
package tmh_pkg;
	localparam logic [2:0] ACT_ADD    = 3'd0;
	localparam logic [2:0] ACT_REMOVE = 3'd1;
	localparam logic [2:0] ACT_REARM  = 3'd2;
	localparam logic [2:0] ACT_POP    = 3'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_QUEUED  = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_NOTQ    = 3'd3;
	localparam logic [2:0] ST_EMPTY   = 3'd4;

	localparam int EVENT_BITS = 6;
	localparam int NUM_EVENTS = 64;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  top_event;
		logic        top_expired;
		logic [31:0] remaining_ms;
		logic [6:0]  entry_count;
	} result_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [5:0]  event_id;
		logic [31:0] delay_ms;
		logic [31:0] now_ms;
	} request_t;
endpackage
`default_nettype wire

// ----- rtl/core/tmh_if.sv -----
// valid/ready channel carrying one payload item
// depends on nothing; payload type given as parameter
`default_nettype none
interface tmh_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/timer_min_heap.sv -----
// timer heap top level: sequencer around the heap memory and the event position map
// depends on tmh_pkg and tmh_if
//
// one item at a time: the next item can be taken in the same cycle as its result appears, and a result
// left waiting holds the following item at its output step
// reset clears the position map by a sweep over all 64 events, no item accepted meanwhile
`default_nettype none
module timer_min_heap #(
	parameter int HEAP_DEPTH = 64,
	parameter int TIME_BITS  = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tmh_if.sink   req,
	tmh_if.source rsp
);
	import tmh_pkg::*;

	localparam int PB = $clog2(HEAP_DEPTH + 1) + 1; // position width (1..DEPTH, plus child math)
	localparam int AB = $clog2(HEAP_DEPTH);
	localparam logic [TIME_BITS-1:0] TMAX = '1;

	localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_LOOK = 4'd2, S_DEC = 4'd3,
		S_RLAST = 4'd4, S_FIX = 4'd5, S_UPRD = 4'd6, S_UPCMP = 4'd7,
		S_DNRD = 4'd8, S_DNRD2 = 4'd9, S_DNCMP = 4'd10, S_TOP = 4'd11, S_TOPW = 4'd12,
		S_OUT = 4'd13, S_PLACE = 4'd14, S_RESP = 4'd15;

	// heap memory: deadline and owner per slot
	logic [TIME_BITS-1:0] dl_mem [HEAP_DEPTH];
	logic [5:0]           ow_mem [HEAP_DEPTH];
	logic [PB-1:0]        pos_mem [NUM_EVENTS];

	logic [3:0] state_q;
	logic [PB-1:0] cnt_q, p_q, c_q, tgtp_q;
	logic [TIME_BITS-1:0] d_q, rd_d_q, cd_q;
	logic [5:0] o_q, rd_o_q, co_q;
	request_t req_q;
	logic [2:0] st_q;
	logic pop_q;
	logic [TIME_BITS-1:0] pd_q;
	logic [5:0] po_q;
	logic [PB-1:0] pos_rd_q;
	result_t res_q;
	logic out_v_q;
	logic [5:0] clr_q;
	logic down_q;

	// memory ports
	logic hw_en, hr_en, pw_en;
	logic [AB-1:0] hw_a, hr_a;
	logic [TIME_BITS-1:0] hw_d;
	logic [5:0] hw_o, pw_a, pr_a;
	logic [PB-1:0] pw_d;

	logic up_go, emit;

	always_ff @(posedge clk) begin
		if (hw_en) begin
			dl_mem[hw_a] <= hw_d;
			ow_mem[hw_a] <= hw_o;
		end
		if (hr_en) begin
			rd_d_q <= dl_mem[hr_a];
			rd_o_q <= ow_mem[hr_a];
		end
		if (pw_en) pos_mem[pw_a] <= pw_d;
		pos_rd_q <= pos_mem[pr_a];
	end

	function automatic logic [TIME_BITS-1:0] expiry(input logic [31:0] now,
		input logic [31:0] dly);
		logic [TIME_BITS:0] s;
		s = {1'b0, TIME_BITS'(now)} + {1'b0, TIME_BITS'(dly)};
		return s[TIME_BITS] ? TMAX : s[TIME_BITS-1:0];
	endfunction

	function automatic logic [AB-1:0] ad(input logic [PB-1:0] p);
		logic [PB-1:0] t;
		t = p - PB'(1);
		return t[AB-1:0];
	endfunction

	logic [TIME_BITS-1:0] now_t, rem_t;
	logic [TIME_BITS-1:0] rep_d;
	assign now_t = TIME_BITS'(req_q.now_ms);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_v_q;
	assign rsp.data  = res_q;

	// a replaced entry starts upward only when strictly earlier than its parent
	assign up_go = (p_q > PB'(1)) && (down_q ? (rd_d_q > d_q) : !(rd_d_q < d_q));
	assign emit  = (state_q == S_RESP) && (!out_v_q || rsp.ready);

	always_comb begin
		hw_en = 1'b0; hr_en = 1'b0; pw_en = 1'b0;
		hw_a = '0; hr_a = '0; hw_d = d_q; hw_o = o_q;
		pw_a = o_q; pw_d = p_q; pr_a = req.data.event_id;
		case (state_q)
			S_CLR: begin pw_en = 1'b1; pw_a = clr_q; pw_d = '0; end
			S_TOPW: begin hr_en = 1'b1; hr_a = '0; end
			S_DEC: begin
				pw_en = 1'b1; pw_a = pop_q ? rd_o_q : req_q.event_id; pw_d = '0;
			end
			S_RLAST: begin hr_en = 1'b1; hr_a = ad(cnt_q); end
			S_FIX: begin hr_en = 1'b1; hr_a = ad(p_q >> 1); end
			S_UPRD: begin hr_en = 1'b1; hr_a = ad(p_q >> 1); end
			S_UPCMP: begin
				if (up_go) begin
					hw_en = 1'b1; hw_a = ad(p_q); hw_d = rd_d_q; hw_o = rd_o_q;
					pw_en = 1'b1; pw_a = rd_o_q; pw_d = p_q;
				end
			end
			S_DNRD: begin hr_en = 1'b1; hr_a = ad(p_q << 1); end
			S_DNRD2: begin hr_en = 1'b1; hr_a = ad((p_q << 1) + PB'(1)); end
			S_DNCMP: ;
			S_OUT: begin
				hw_en = 1'b1; hw_a = ad(p_q); hw_d = cd_q; hw_o = co_q;
				pw_en = 1'b1; pw_a = co_q; pw_d = p_q;
			end
			S_PLACE: begin
				hw_en = 1'b1; hw_a = ad(p_q);
				pw_en = 1'b1;
			end
			S_TOP: begin hr_en = 1'b1; hr_a = '0; end
			default: ;
		endcase
	end

	always_comb begin
		rep_d = pop_q ? pd_q : rd_d_q;
		rem_t = (rep_d > now_t) ? rep_d - now_t : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (emit) out_v_q <= 1'b1;
			else if (rsp.ready) out_v_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 6'd1;
					if (clr_q == 6'd63) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req.valid) begin
						req_q <= req.data; st_q <= ST_OK; pop_q <= 1'b0;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					// pos_rd_q now holds the slot of the requested event
					o_q <= req_q.event_id;
					d_q <= expiry(req_q.now_ms, req_q.delay_ms);
					case (req_q.action)
						ACT_ADD: begin
							if (pos_rd_q != '0) begin st_q <= ST_QUEUED; state_q <= S_TOP; end
							else if (cnt_q >= PB'(HEAP_DEPTH)) begin
								st_q <= ST_FULL; state_q <= S_TOP;
							end else begin
								cnt_q <= cnt_q + PB'(1); p_q <= cnt_q + PB'(1);
								down_q <= 1'b0; state_q <= S_UPRD;
							end
						end
						ACT_REMOVE: begin
							if (pos_rd_q == '0 || pos_rd_q > cnt_q) begin
								st_q <= ST_NOTQ; state_q <= S_TOP;
							end else begin
								tgtp_q <= pos_rd_q; state_q <= S_DEC;
							end
						end
						ACT_REARM: begin
							if (pos_rd_q == '0 || pos_rd_q > cnt_q) begin
								st_q <= ST_NOTQ; state_q <= S_TOP;
							end else begin
								p_q <= pos_rd_q; state_q <= S_FIX;
							end
						end
						ACT_POP: begin
							if (cnt_q == '0) begin st_q <= ST_EMPTY; state_q <= S_TOP; end
							else state_q <= S_TOPW;
						end
						default: begin
							if (cnt_q == '0) st_q <= ST_EMPTY;
							state_q <= S_TOP;
						end
					endcase
				end
				S_TOPW: begin
					// slot 1 is read here for pop
					state_q <= S_DEC; pop_q <= 1'b1; tgtp_q <= PB'(1);
				end
				S_DEC: begin
					// clear position of removed event; for pop, keep the top entry read in S_TOPW
					if (pop_q) begin
						pd_q <= rd_d_q; po_q <= rd_o_q;
					end
					state_q <= S_RLAST;
				end
				S_RLAST: begin
					cnt_q <= cnt_q - PB'(1);
					p_q <= tgtp_q;
					if (tgtp_q == cnt_q) begin
						state_q <= S_TOP;
					end else state_q <= S_FIX;
					o_q <= pop_q ? po_q : req_q.event_id;
				end
				S_FIX: begin
					// entering from rearm: d_q/o_q are the new entry; from remove or pop: last entry
					if (req_q.action != ACT_REARM) begin
						d_q <= rd_d_q; o_q <= rd_o_q;
					end
					state_q <= S_UPCMP; down_q <= 1'b1;
				end
				S_UPRD: state_q <= S_UPCMP;
				S_UPCMP: begin
					if (up_go) begin
						p_q <= p_q >> 1; down_q <= 1'b0; state_q <= S_UPRD;
					end else if (down_q) state_q <= S_DNRD;
					else state_q <= S_PLACE;
				end
				S_DNRD: begin
					if (p_q > (cnt_q >> 1)) state_q <= S_PLACE;
					else state_q <= S_DNRD2;
				end
				S_DNRD2: begin
					cd_q <= rd_d_q; co_q <= rd_o_q; c_q <= p_q << 1;
					state_q <= S_DNCMP;
				end
				S_DNCMP: begin
					// rd_* holds right child if it exists
					if ((c_q + PB'(1) <= cnt_q) && cd_q > rd_d_q) begin
						if (rd_d_q > d_q) state_q <= S_PLACE;
						else begin
							cd_q <= rd_d_q; co_q <= rd_o_q; c_q <= c_q + PB'(1);
							state_q <= S_OUT;
						end
					end else if (cd_q > d_q) state_q <= S_PLACE;
					else state_q <= S_OUT;
				end
				S_OUT: begin
					state_q <= S_DNRD; p_q <= c_q;
				end
				S_PLACE: state_q <= S_TOP;
				S_TOP: state_q <= S_RESP; // wait for read data below
				S_RESP: begin
					if (emit) begin
						res_q.status <= st_q;
						res_q.entry_count <= 7'(cnt_q);
						if (pop_q || cnt_q != '0) begin
							res_q.top_event <= pop_q ? po_q : rd_o_q;
							res_q.top_expired <= (rep_d <= now_t);
							res_q.remaining_ms <= (rem_t > TIME_BITS'(32'hFFFFFFFF)) ?
								32'hFFFFFFFF : 32'(rem_t);
						end else begin
							res_q.top_event <= '0; res_q.top_expired <= 1'b0;
							res_q.remaining_ms <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= PB'(HEAP_DEPTH))
		else $error("heap count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("second item taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.status == ST_EMPTY) |-> rsp.data.entry_count == '0)
		else $error("empty status with queued entries");
endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// testbench for the timer heap: random and directed actions, predicted results checked in order
// depends on tmh_pkg, tmh_if and timer_min_heap
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import tmh_pkg::*;

	localparam int DEPTH = 64;
	localparam int WATCHDOG = 1000;
	localparam logic [2:0] ACT_QUERY = 3'd4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tmh_if #(.payload_t(request_t)) req ();
	tmh_if #(.payload_t(result_t)) rsp ();

	timer_min_heap DUT (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [31:0] dl [1:DEPTH];
	logic [5:0]  own [1:DEPTH];
	int          pos_of [0:63];
	int          heap_n;

	request_t pending [$];
	result_t  expected_results [$];
	int       fails = 0;
	bit       stim_done = 0;
	bit       hold_long = 0;
	int       idle_cycles = 0;

	function automatic void put(int p, logic [31:0] d, logic [5:0] o);
		dl[p] = d;
		own[p] = o;
		pos_of[o] = p;
	endfunction

	function automatic void rise(int p);
		logic [31:0] d;
		logic [5:0] o;
		d = dl[p];
		o = own[p];
		while (p > 1) begin
			if (dl[p >> 1] < d) break;
			put(p, dl[p >> 1], own[p >> 1]);
			p = p >> 1;
		end
		put(p, d, o);
	endfunction

	function automatic void sink_down(int p);
		logic [31:0] d;
		logic [5:0] o;
		int c;
		d = dl[p];
		o = own[p];
		while (p <= (heap_n >> 1)) begin
			c = p << 1;
			if (c + 1 <= heap_n && dl[c] > dl[c + 1]) c++;
			if (dl[c] > d) break;
			put(p, dl[c], own[c]);
			p = c;
		end
		put(p, d, o);
	endfunction

	function automatic void repair(int p);
		if (p > 1 && dl[p >> 1] > dl[p]) rise(p);
		else sink_down(p);
	endfunction

	function automatic void take_out(logic [5:0] e);
		int p;
		int last;
		p = pos_of[e];
		last = heap_n;
		pos_of[e] = 0;
		if (p == 0 || p > last) return;
		heap_n = last - 1;
		if (p != last) begin
			put(p, dl[last], own[last]);
			repair(p);
		end
	endfunction

	function automatic logic [31:0] deadline(logic [31:0] now, logic [31:0] dly);
		logic [32:0] s;
		s = {1'b0, now} + {1'b0, dly};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic result_t timer_step(request_t r);
		result_t res;
		logic [31:0] rd;
		logic [5:0] ro;
		bit show;
		int p;
		res = '0;
		res.status = ST_OK;
		show = 0;
		case (r.action)
			ACT_ADD: begin
				if (pos_of[r.event_id] != 0) res.status = ST_QUEUED;
				else if (heap_n >= DEPTH) res.status = ST_FULL;
				else begin
					heap_n++;
					put(heap_n, deadline(r.now_ms, r.delay_ms), r.event_id);
					rise(heap_n);
				end
			end
			ACT_REMOVE: begin
				if (pos_of[r.event_id] == 0) res.status = ST_NOTQ;
				else take_out(r.event_id);
			end
			ACT_REARM: begin
				p = pos_of[r.event_id];
				if (p == 0 || p > heap_n) res.status = ST_NOTQ;
				else begin
					put(p, deadline(r.now_ms, r.delay_ms), r.event_id);
					repair(p);
				end
			end
			ACT_POP: begin
				if (heap_n == 0) res.status = ST_EMPTY;
				else begin
					rd = dl[1];
					ro = own[1];
					show = 1;
					take_out(ro);
				end
			end
			default: if (heap_n == 0) res.status = ST_EMPTY;
		endcase
		if (!show && heap_n > 0) begin
			rd = dl[1];
			ro = own[1];
			show = 1;
		end
		if (show) begin
			res.top_event = ro;
			res.top_expired = (rd <= r.now_ms);
			res.remaining_ms = (rd > r.now_ms) ? rd - r.now_ms : 32'd0;
		end
		res.entry_count = heap_n[6:0];
		return res;
	endfunction

	// sender
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.data <= '0;
			send_gap = 0;
		end else begin
			if (req.valid && req.ready) begin
				expected_results.push_back(timer_step(req.data));
				void'(pending.pop_front());
			end
			if (req.valid && !req.ready) begin
				// offered item holds until taken
			end else if (send_gap > 0) begin
				send_gap--;
				req.valid <= 1'b0;
			end else if (pending.size() > 0) begin
				req.valid <= 1'b1;
				req.data <= pending[0];
				if ($urandom_range(0, 3) == 0)
					send_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
						: $urandom_range(0, 3);
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// receiver
	int recv_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result item %p", rsp.data);
					fails++;
				end else begin
					result_t x;
					x = expected_results.pop_front();
					if (x.status !== rsp.data.status) begin
						$error("status exp %0d got %0d", x.status, rsp.data.status);
						fails++;
					end
					if (x.top_event !== rsp.data.top_event) begin
						$error("top_event exp %0d got %0d", x.top_event, rsp.data.top_event);
						fails++;
					end
					if (x.top_expired !== rsp.data.top_expired) begin
						$error("top_expired exp %0d got %0d", x.top_expired,
							rsp.data.top_expired);
						fails++;
					end
					if (x.remaining_ms !== rsp.data.remaining_ms) begin
						$error("remaining_ms exp %0h got %0h", x.remaining_ms,
							rsp.data.remaining_ms);
						fails++;
					end
					if (x.entry_count !== rsp.data.entry_count) begin
						$error("entry_count exp %0d got %0d", x.entry_count,
							rsp.data.entry_count);
						fails++;
					end
				end
			end
			if (hold_long) begin
				rsp.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
				if ($urandom_range(0, 4) == 0)
					recv_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
						: $urandom_range(0, 3);
			end
		end
	end

	// watchdog on accepted items
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || hold_long)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	function automatic request_t make_req(logic [2:0] a, logic [5:0] e,
		logic [31:0] d, logic [31:0] n);
		request_t r;
		r.action = a;
		r.event_id = e;
		r.delay_ms = d;
		r.now_ms = n;
		return r;
	endfunction

	function automatic logic [31:0] pick_time();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 50);
			3: return 32'hFFFF_FFFF - $urandom_range(0, 50);
			default: return $urandom();
		endcase
	endfunction

	initial begin
		logic [31:0] clock_now;
		logic [2:0] a;
		int k;
		for (int i = 0; i < 64; i++) pos_of[i] = 0;
		heap_n = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty pop/query, extremes, saturation, duplicates, misses, equal deadlines
		pending.push_back(make_req(ACT_POP, 6'd0, 32'd0, 32'd0));
		pending.push_back(make_req(ACT_QUERY, 6'd0, 32'd0, 32'hFFFF_FFFF));
		pending.push_back(make_req(ACT_REMOVE, 6'd5, 32'd0, 32'd0));
		pending.push_back(make_req(ACT_REARM, 6'd5, 32'd1, 32'd0));
		pending.push_back(make_req(ACT_ADD, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pending.push_back(make_req(ACT_ADD, 6'd0, 32'd0, 32'd0));
		pending.push_back(make_req(ACT_ADD, 6'd0, 32'd7, 32'd0));
		pending.push_back(make_req(ACT_ADD, 6'd1, 32'd10, 32'd0));
		pending.push_back(make_req(ACT_ADD, 6'd2, 32'd10, 32'd0));
		pending.push_back(make_req(ACT_ADD, 6'd3, 32'd10, 32'd0));
		pending.push_back(make_req(ACT_QUERY, 6'd0, 32'd0, 32'd5));
		pending.push_back(make_req(ACT_REARM, 6'd0, 32'd20, 32'd0));
		pending.push_back(make_req(ACT_REARM, 6'd63, 32'd1, 32'd0));
		pending.push_back(make_req(ACT_REMOVE, 6'd1, 32'd0, 32'd3));
		pending.push_back(make_req(3'd5, 6'd0, 32'd0, 32'd0));
		pending.push_back(make_req(3'd6, 6'd0, 32'd0, 32'd11));
		pending.push_back(make_req(3'd7, 6'h2A, 32'hAAAA_AAAA, 32'h5555_5555));
		for (int i = 0; i < 6; i++)
			pending.push_back(make_req(ACT_POP, 6'd0, 32'd0, 32'd10));

		// fill to full, then add an event already queued, with the receiver holding off meanwhile
		for (int i = 0; i < 64; i++)
			pending.push_back(make_req(ACT_ADD, i[5:0], $urandom_range(0, 1000), 32'd0));
		pending.push_back(make_req(ACT_ADD, 6'd9, 32'd1, 32'd0));
		wait (pending.size() < 60);
		hold_long = 1;
		repeat (300) @(posedge clk);
		hold_long = 0;
		// remove from the middle so replacements sift both ways
		for (int i = 0; i < 64; i++)
			pending.push_back(make_req(i[0] ? ACT_REMOVE : ACT_POP, 6'(i * 37),
				32'd0, 32'd500));

		// random: mostly a moving clock and mixed actions over a modest pool of events
		clock_now = 0;
		for (int i = 0; i < 1700; i++) begin
			k = $urandom_range(0, 99);
			if (k < 40) a = ACT_ADD;
			else if (k < 55) a = ACT_REMOVE;
			else if (k < 70) a = ACT_REARM;
			else if (k < 90) a = ACT_POP;
			else a = 3'($urandom_range(4, 7));
			if ($urandom_range(0, 19) == 0) clock_now = pick_time();
			else clock_now = clock_now + $urandom_range(0, 20);
			pending.push_back(make_req(a, 6'(($urandom_range(0, 3) == 0) ? $urandom()
				: $urandom_range(0, 15)), ($urandom_range(0, 9) == 0) ? pick_time()
				: $urandom_range(0, 200), clock_now));
			if (i % 100 == 0) wait (pending.size() < 50);
		end
		wait (pending.size() == 0 && !req.valid);
		wait (expected_results.size() == 0);
		repeat (40) @(posedge clk);
		if (fails == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/core/tmh_pkg.sv
rtl/core/tmh_if.sv
rtl/core/timer_min_heap.sv
tb/sv/tb_top.sv
